// ===== design/gb3_pkg.sv =====
package gb3_pkg;

   localparam int PIXEL_W       = 8;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 12;
   localparam int ROW_W         = 12;
   localparam int WIDTH_CMP_W   = 13;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 12;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MIN_DIM       = 3;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [PIXEL_W-1:0] pixel_type;

   // per-request flags handed from the raster scan to the datapath
   typedef struct packed {
      logic emit;
      logic frame_end;
   } scan_info_type;

endpackage

// ===== design/gaussian_blur_3x3_stream_core.sv =====
// 3x3 gaussian blur (1-2-1 / 2-4-2 / 1-2-1, divided by 16) over 8-bit grayscale pixels
// streamed in raster order. One pixel is taken per clock while no stalled result holds the input;
// a blurred value comes out for every interior pixel from the request that completes its
// neighbourhood, through the input stage and then the output register, and border pixels produce
// nothing. The rate is set by the two line RAMs, each doing one read and one write per cycle.
// rsp_frame_last marks the last interior pixel of a frame. Line RAMs need no clearing after reset.
// Write image_width/image_height only while idle; a smaller size during a frame ends that frame early.
module gaussian_blur_3x3_stream_core import gb3_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_pixel_out,
   output logic                   rsp_frame_last
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic             accept;
   logic             a_go;
   logic [COL_W-1:0] col;
   scan_info_type    info;
   pixel_type        top_px;
   pixel_type        mid_px;
   pixel_type        blur_px;

   logic             a_vld_ff, a_vld_in;
   pixel_type        a_pix_ff;
   scan_info_type    a_info_ff;
   logic             wr_pend_ff;
   logic [COL_W-1:0] wr_col_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   pixel_type        rsp_pixel_ff;
   logic             rsp_last_ff;

   assign a_go      = a_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_vld_ff && !a_go;
   assign accept    = req_valid && !req_stall;

   gb3_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .col       (col),
      .info      (info)
   );

   // row above: new pixel goes in at the column it is read from
   gb3_ram #(.DATA_W(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_above (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col),
      .wr_data (req_pixel_in),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (mid_px)
   );

   // two rows above: fed from the row above's read data in the cycle after the read
   gb3_ram #(.DATA_W(PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_above_above (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_col_ff),
      .wr_data (mid_px),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (top_px)
   );

   gb3_kernel u_kernel (
      .clock (clock),
      .reset (reset),
      .shift (a_go),
      .top   (top_px),
      .mid   (mid_px),
      .bot   (a_pix_ff),
      .blur  (blur_px)
   );

   assign a_vld_in = accept || (a_vld_ff && !a_go);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (a_go) begin
         rsp_valid_in = a_info_ff.emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= a_vld_in;
         wr_pend_ff   <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_col_ff <= col;
      if (accept) begin
         a_pix_ff  <= req_pixel_in;
         a_info_ff <= info;
      end
      if (a_go && a_info_ff.emit) begin
         rsp_pixel_ff <= blur_px;
         rsp_last_ff  <= a_info_ff.frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ===== design/gb3_ram.sv =====
module gb3_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gb3_scan.sv =====
module gb3_scan import gb3_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   accept,
   output logic [COL_W-1:0]       col,
   output scan_info_type          info
);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;

   logic [WIDTH_CMP_W-1:0]  w_ext;
   logic [WIDTH_CMP_W-1:0]  w_use;
   logic [COL_W-1:0]        col_last;
   logic [HEIGHT_REG_W-1:0] h_use;
   logic [ROW_W-1:0]        row_last;
   logic                    last_col;
   logic                    last_row;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // width clamped to 3..MAX_WIDTH, height raised to at least 3
   always_comb begin
      w_ext = WIDTH_CMP_W'(width_ff);
      if (w_ext < WIDTH_CMP_W'(MIN_DIM)) begin
         w_use = WIDTH_CMP_W'(MIN_DIM);
      end else if (w_ext > WIDTH_CMP_W'(MAX_WIDTH)) begin
         w_use = WIDTH_CMP_W'(MAX_WIDTH);
      end else begin
         w_use = w_ext;
      end
      col_last = COL_W'(w_use - WIDTH_CMP_W'(1));
      h_use = (height_ff < HEIGHT_REG_W'(MIN_DIM)) ? HEIGHT_REG_W'(MIN_DIM) : height_ff;
      row_last = ROW_W'(h_use - HEIGHT_REG_W'(1));
   end

   // >= rather than == so a shrunk frame wraps at the next advance
   assign last_col = (col_ff >= col_last);
   assign last_row = (row_ff >= row_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   assign col            = col_ff;
   assign info.emit      = (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
   assign info.frame_end = last_col && last_row;

endmodule

// ===== design/gb3_kernel.sv =====
module gb3_kernel import gb3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  pixel_type top,
   input  pixel_type mid,
   input  pixel_type bot,
   output pixel_type blur
);

   localparam int SUM_W = PIXEL_W + 4;

   // [row*2 + k]: row 0 top .. 2 bottom, k 0 older, 1 newer
   pixel_type win_ff [6];
   pixel_type win_in [6];

   logic [SUM_W-1:0] sum;

   always_comb begin
      sum = SUM_W'(win_ff[0]) + (SUM_W'(win_ff[1]) << 1) + SUM_W'(top)
          + (SUM_W'(win_ff[2]) << 1) + (SUM_W'(win_ff[3]) << 2) + (SUM_W'(mid) << 1)
          + SUM_W'(win_ff[4]) + (SUM_W'(win_ff[5]) << 1) + SUM_W'(bot);
   end

   // kernel weights add to 16, so sum/16 never exceeds 255
   assign blur = sum[SUM_W-1:4];

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = top;
      win_in[2] = win_ff[3];
      win_in[3] = mid;
      win_in[4] = win_ff[5];
      win_in[5] = bot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

// ===== design/gb3_checker.sv =====
module gb3_checker import gb3_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [PIXEL_W-1:0] rsp_pixel_out,
   input logic               rsp_frame_last
);

   // a held result stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
                                 && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // the input side only backs up behind a stalled result
   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with no result waiting");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // a stall right after an empty output needs a request made while the output was empty
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !req_stall || $past(req_valid))
      else $error("request stalled without an earlier request");

endmodule

bind gaussian_blur_3x3_stream_core gb3_checker u_gb3_checker (.*);

// ===== verif/tb_gaussian_blur_3x3_stream_core.sv =====
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3_stream_core;
   import gb3_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = 8;
   localparam int END_CYCLES      = 20;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int MAX_GAP         = 19;
   localparam int RANDOM_ITEMS    = 1300;
   localparam int PIXEL_MAX       = 255;
   localparam int KERNEL_NORM     = 16;
   localparam int SHRINK_CAP      = 8;
   localparam int WIDE_FRAME      = 2;
   localparam int TALL_FRAME      = 4;
   localparam int BURST_FRAME     = 6;
   localparam int BURST_WIDTH     = 24;
   localparam int BURST_HEIGHT    = 6;
   localparam int COL_BITS        = $clog2(DEF_MAX_WIDTH);

   typedef struct packed {
      pixel_type pixel_out;
      logic      frame_last;
   } blur_result_type;

   typedef enum logic {
      STEP_PIXEL,
      STEP_CSR
   } step_kind_type;

   typedef struct packed {
      step_kind_type            kind;
      logic [CSR_INDEX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]    data;
      logic                     typed;
      blur_result_type          expected;
   } directed_step_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_wr_en      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata      = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel_in   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_out;
   logic                   rsp_frame_last;

   // blur predictor state
   logic [WIDTH_REG_W-1:0]  width_setting  = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] height_setting = HEIGHT_RESET;
   pixel_type               row_above2 [DEF_MAX_WIDTH];
   pixel_type               row_above  [DEF_MAX_WIDTH];
   // [row*2 + k]: row 0 top .. 2 bottom, k 0 older column, 1 newer column
   pixel_type               window [6];
   int unsigned             scan_col = 0;
   int unsigned             scan_row = 0;

   blur_result_type         pending_blur [$];
   blur_result_type         oldest_blur;
   directed_step_type       directed_steps [$];
   int unsigned             error_count   = 0;
   int unsigned             quiet_cycles  = 0;
   int unsigned             req_calm      = 0;
   int unsigned             rsp_calm      = 0;
   bit                      hold_results  = 1'b0;
   bit                      sender_no_gap = 1'b0;

   gaussian_blur_3x3_stream_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic int unsigned width_in_use();
      int unsigned w;
      w = 32'(width_setting);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned height_in_use();
      int unsigned h;
      h = 32'(height_setting);
      if (h < MIN_DIM) h = MIN_DIM;
      return h;
   endfunction

   function automatic logic blur_predict(input pixel_type pix, output blur_result_type result);
      int unsigned         w, h, col, sum;
      logic [COL_BITS-1:0] idx;
      pixel_type           top, mid;
      logic                last_col, last_row, emit;
      w        = width_in_use();
      h        = height_in_use();
      col      = (scan_col >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : scan_col;
      idx      = COL_BITS'(col);
      top      = row_above2[idx];
      mid      = row_above[idx];
      last_col = (scan_col >= w - 1);
      last_row = (scan_row >= h - 1);
      emit     = (scan_col >= 2) && (scan_row >= 2);
      sum = 32'(window[0]) + 2 * 32'(window[1]) + 32'(top)
          + 2 * 32'(window[2]) + 4 * 32'(window[3]) + 2 * 32'(mid)
          + 32'(window[4]) + 2 * 32'(window[5]) + 32'(pix);
      sum = sum / KERNEL_NORM;
      if (sum > PIXEL_MAX) sum = PIXEL_MAX;
      result.pixel_out  = pixel_type'(sum);
      result.frame_last = last_col && last_row;
      window[0] = window[1];
      window[1] = top;
      window[2] = window[3];
      window[3] = mid;
      window[4] = window[5];
      window[5] = pix;
      row_above2[idx] = mid;
      row_above[idx]  = pix;
      if (last_col) begin
         scan_col = 0;
         scan_row = last_row ? 0 : scan_row + 1;
      end else begin
         scan_col = scan_col + 1;
      end
      return emit;
   endfunction

   // stretches of back-to-back traffic between random gaps
   function automatic int unsigned draw_gap(inout int unsigned calm_left);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void add_pixel(input pixel_type pix);
      directed_steps.push_back({STEP_PIXEL, REG_IMAGE_WIDTH, CSR_DATA_W'(pix), 1'b0,
                                blur_result_type'('0)});
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] data);
      directed_steps.push_back({STEP_CSR, index, data, 1'b0, blur_result_type'('0)});
   endfunction

   function automatic void add_checked(input pixel_type pix, input pixel_type blurred,
                                       input logic last);
      directed_steps.push_back({STEP_PIXEL, REG_IMAGE_WIDTH, CSR_DATA_W'(pix), 1'b1,
                                blurred, last});
   endfunction

   task automatic send_pixel(input pixel_type pix, input logic typed,
                             input blur_result_type typed_result);
      int unsigned     gap;
      logic            emits;
      blur_result_type predicted;
      gap = sender_no_gap ? 0 : draw_gap(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      emits = blur_predict(pix, predicted);
      if (typed) pending_blur.push_back(typed_result);
      else if (emits) pending_blur.push_back(predicted);
   endtask

   // block may still be busy on a request that gives no result
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_blur.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == REG_IMAGE_WIDTH) width_setting = data[WIDTH_REG_W-1:0];
      else height_setting = data[HEIGHT_REG_W-1:0];
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned           frame_no, random_items, n, cut, cap;
      pixel_type             pix;
      logic [CSR_DATA_W-1:0] w_raw, h_raw;
      frame_no     = 0;
      random_items = 0;
      pix          = '0;
      foreach (row_above[i]) begin
         row_above[i]  = '0;
         row_above2[i] = '0;
      end
      foreach (window[i]) window[i] = '0;

      // first row at the reset size, then the width shrinks under it
      repeat (4) add_pixel(8'd255);
      add_csr(REG_IMAGE_WIDTH, CSR_DATA_W'(2));
      add_pixel(8'd255);
      repeat (3) add_pixel(8'd255);
      add_csr(REG_IMAGE_HEIGHT, CSR_DATA_W'(0));
      repeat (2) add_pixel(8'd255);
      add_checked(8'd255, 8'd255, 1'b1);
      // lone bright centre: 4 * 255 / 16
      repeat (4) add_pixel(8'd0);
      add_pixel(8'd255);
      repeat (3) add_pixel(8'd0);
      add_checked(8'd0, 8'd63, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            wait_quiet();
            write_csr(directed_steps[i].index, directed_steps[i].data);
         end else begin
            send_pixel(directed_steps[i].data[PIXEL_W-1:0], directed_steps[i].typed,
                       directed_steps[i].expected);
         end
      end

      while (random_items < RANDOM_ITEMS || frame_no <= BURST_FRAME) begin
         wait_quiet();
         cut = 0;
         case (frame_no)
            WIDE_FRAME: begin
               w_raw = '1;
               h_raw = CSR_DATA_W'(MIN_DIM);
            end
            TALL_FRAME: begin
               w_raw = CSR_DATA_W'($urandom_range(MIN_DIM, MIN_DIM + 1));
               h_raw = '1;
            end
            BURST_FRAME: begin
               w_raw = CSR_DATA_W'(BURST_WIDTH);
               h_raw = CSR_DATA_W'(BURST_HEIGHT);
            end
            default: begin
               case ($urandom_range(0, 7))
                  0:       w_raw = CSR_DATA_W'($urandom_range(0, MIN_DIM - 1));
                  1:       w_raw = CSR_DATA_W'($urandom_range(11, 40));
                  default: w_raw = CSR_DATA_W'($urandom_range(MIN_DIM, 10));
               endcase
               case ($urandom_range(0, 7))
                  0:       h_raw = CSR_DATA_W'($urandom_range(0, MIN_DIM - 1));
                  1:       h_raw = CSR_DATA_W'($urandom_range(7, 10));
                  default: h_raw = CSR_DATA_W'($urandom_range(MIN_DIM, 6));
               endcase
            end
         endcase
         write_csr(REG_IMAGE_WIDTH, w_raw);
         write_csr(REG_IMAGE_HEIGHT, h_raw);

         case (frame_no)
            WIDE_FRAME:  cut = DEF_MAX_WIDTH + $urandom_range(1, 3);
            TALL_FRAME:  cut = width_in_use() * $urandom_range(3, 6);
            BURST_FRAME: begin
               // receiver holds off while the sender floods
               sender_no_gap = 1'b1;
               hold_results  = 1'b1;
            end
            default: begin
               if ($urandom_range(0, 4) == 0)
                  cut = $urandom_range(1, width_in_use() * height_in_use() - 1);
            end
         endcase

         n = 0;
         do begin
            if (cut != 0 && n == cut) begin
               // only shrink the width mid-frame: a wider line reads entries never written
               wait_quiet();
               cap = width_in_use();
               if (cap > SHRINK_CAP) cap = SHRINK_CAP;
               write_csr(REG_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(0, cap)));
               write_csr(REG_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(0, SHRINK_CAP)));
            end
            case ($urandom_range(0, 7))
               0:       pix = '0;
               1:       pix = '1;
               2, 3:    pix = pix + pixel_type'($urandom_range(0, 15)) - pixel_type'(8);
               default: pix = pixel_type'($urandom_range(0, PIXEL_MAX));
            endcase
            send_pixel(pix, 1'b0, blur_result_type'('0));
            n++;
         end while (scan_col != 0 || scan_row != 0);
         sender_no_gap = 1'b0;
         random_items += n;
         frame_no++;
      end

      wait_quiet();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin : result_drain
      int unsigned pause;
      @(posedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            pause        = RSP_HOLD_CYCLES;
         end else begin
            pause = draw_gap(rsp_calm);
         end
         if (pause != 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blur.size() == 0) begin
            $error("result with nothing pending: pixel_out %0d frame_last %0b",
                   rsp_pixel_out, rsp_frame_last);
            error_count++;
         end else begin
            oldest_blur = pending_blur.pop_front();
            if (rsp_pixel_out !== oldest_blur.pixel_out) begin
               $error("pixel_out: expected %0d, got %0d", oldest_blur.pixel_out, rsp_pixel_out);
               error_count++;
            end
            if (rsp_frame_last !== oldest_blur.frame_last) begin
               $error("frame_last: expected %0b, got %0b", oldest_blur.frame_last,
                      rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $error("no request or result moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
